[hw/rtl/dfl_pkg.sv]
// Shared types, codes, character constants and word test for the definition file lexer.
`default_nettype none

package dfl_pkg;

    localparam int unsigned LINE_BITS_DEF = 16;
    localparam int unsigned COL_BITS_DEF  = 16;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        EV_CHAR  = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } t_event_kind;

    typedef enum logic [2:0] {
        TK_LITERAL = 3'd0,
        TK_QUOTED  = 3'd1,
        TK_BARE    = 3'd2,
        TK_CODE    = 3'd3,
        TK_COMMENT = 3'd4,
        TK_EOI     = 3'd5
    } t_token_kind;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_INVALID    = 3'd1,
        ERR_NO_QUOTE   = 3'd2,
        ERR_UNEXP_END  = 3'd3,
        ERR_AFTER_END  = 3'd4
    } t_error_code;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_LC_N    = 8'h6E;
    localparam logic [7:0] CH_LC_R    = 8'h72;
    localparam logic [7:0] CH_LC_T    = 8'h74;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef struct packed {
        t_event_kind kind;
        t_token_kind tok;
        logic [7:0]  chr;
        logic [15:0] line;
        logic [15:0] col;
        t_error_code err;
        logic        last;
    } t_event;

    function automatic logic is_word(input logic [7:0] c);
        logic w;
        begin
            w = 1'b0;
            if (c >= 8'h61 && c <= 8'h7A) w = 1'b1;
            if (c >= 8'h41 && c <= 8'h5A) w = 1'b1;
            if (c >= 8'h30 && c <= 8'h39) w = 1'b1;
            if (c == CH_USCORE || c == CH_MINUS || c == CH_PLUS || c == CH_COLON ||
                c == CH_SEMI || c == CH_DOT || c == CH_LBRACK || c == CH_RBRACK ||
                c == CH_LT || c == CH_GT) w = 1'b1;
            return w;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/definition_file_lexer.sv]
// Definition file lexer: one character per transfer in, token and error events out.
// Each input transfer carries one byte or an end-of-input marker and is decoded in the
// cycle it arrives against the registered lexer mode, line/column counters and token
// start position; its zero to three events go into a four-entry result queue that
// drains one event per cycle unless the output stalls. An item with at most one result
// does not hold the input, so such items stream at one per cycle while the output
// keeps up; an item with two or three events (a literal, a bare word closed by a
// literal or a bad byte, or an end marker that closes an open token) holds the input
// until at most one event is queued. Line and column counters saturate at all ones;
// events carry their low 16 bits. After an error the block drops every further item.
`default_nettype none

module definition_file_lexer #(
    parameter int unsigned LINE_BITS = dfl_pkg::LINE_BITS_DEF,
    parameter int unsigned COL_BITS  = dfl_pkg::COL_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_end_of_input,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_event_kind,
    output logic [2:0]       o_token_kind,
    output logic [7:0]       o_char_value,
    output logic [15:0]      o_start_line,
    output logic [15:0]      o_start_col,
    output logic [2:0]       o_error_code,
    output logic             o_last
);
    import dfl_pkg::*;

    typedef enum logic [2:0] {
        M_INIT    = 3'd0,
        M_QUOTE   = 3'd1,
        M_ESC     = 3'd2,
        M_BARE    = 3'd3,
        M_CODE    = 3'd4,
        M_COMMENT = 3'd5,
        M_ENDED   = 3'd6,
        M_FAILED  = 3'd7
    } t_mode;

    typedef struct packed {
        logic [1:0] num;
        t_event     e0;
        t_event     e1;
        t_mode      mode;
        logic       mark;
    } t_scan;

    localparam int unsigned CW = Q_AW + 1;

    t_mode                r_mode, n_mode;
    logic [LINE_BITS-1:0] r_line, n_line, r_tline, n_tline;
    logic [COL_BITS-1:0]  r_col, n_col, r_tcol, n_tcol;
    t_event               r_q [Q_DEPTH];
    logic [Q_AW-1:0]      r_rd, r_wr;
    logic [CW-1:0]        r_cnt, n_cnt;

    logic                 accept, pop;
    logic [1:0]           num;
    t_event               ev [3];
    t_scan                sc;
    logic [LINE_BITS+15:0] ext_line, ext_tline;
    logic [COL_BITS+15:0]  ext_col, ext_tcol;
    logic [15:0]          line16, col16, tline16, tcol16;
    logic [7:0]           esc_c;
    t_token_kind          mode_tok;

    function automatic t_event mk_event(input t_event_kind k, input t_token_kind t,
                                        input logic [7:0] c, input logic [15:0] l,
                                        input logic [15:0] cl, input t_error_code e);
        t_event r;
        begin
            r.kind = k;
            r.tok  = t;
            r.chr  = c;
            r.line = l;
            r.col  = cl;
            r.err  = e;
            r.last = 1'b0;
            return r;
        end
    endfunction

    function automatic t_scan scan_initial(input logic [7:0] c, input logic [15:0] l,
                                           input logic [15:0] cl);
        t_scan s;
        begin
            s      = '0;
            s.mode = M_INIT;
            case (c)
                CH_DQUOTE: begin
                    s.mark = 1'b1;
                    s.mode = M_QUOTE;
                end
                CH_PERCENT: begin
                    s.mark = 1'b1;
                    s.mode = M_CODE;
                end
                CH_HASH: begin
                    s.mark = 1'b1;
                    s.mode = M_COMMENT;
                end
                CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA: begin
                    s.mark = 1'b1;
                    s.num  = 2'd2;
                    s.e0   = mk_event(EV_CHAR, TK_LITERAL, c, 16'd0, 16'd0, ERR_NONE);
                    s.e1   = mk_event(EV_END, TK_LITERAL, 8'd0, l, cl, ERR_NONE);
                end
                CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
                end
                default: begin
                    if (is_word(c)) begin
                        s.mark = 1'b1;
                        s.mode = M_BARE;
                        s.num  = 2'd1;
                        s.e0   = mk_event(EV_CHAR, TK_BARE, c, 16'd0, 16'd0, ERR_NONE);
                    end else begin
                        s.mode = M_FAILED;
                        s.num  = 2'd1;
                        s.e0   = mk_event(EV_ERROR, TK_LITERAL, 8'd0, l, cl, ERR_INVALID);
                    end
                end
            endcase
            return s;
        end
    endfunction

    assign o_stall = (r_cnt > CW'(1));
    assign accept  = i_valid && !o_stall;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;

    assign o_event_kind = r_q[r_rd].kind;
    assign o_token_kind = r_q[r_rd].tok;
    assign o_char_value = r_q[r_rd].chr;
    assign o_start_line = r_q[r_rd].line;
    assign o_start_col  = r_q[r_rd].col;
    assign o_error_code = r_q[r_rd].err;
    assign o_last       = r_q[r_rd].last;

    assign ext_line  = {16'd0, n_line};
    assign ext_col   = {16'd0, n_col};
    assign ext_tline = {16'd0, r_tline};
    assign ext_tcol  = {16'd0, r_tcol};
    assign line16    = ext_line[15:0];
    assign col16     = ext_col[15:0];
    assign tline16   = ext_tline[15:0];
    assign tcol16    = ext_tcol[15:0];

    assign sc = scan_initial(i_byte_value, line16, col16);

    always_comb begin
        case (i_byte_value)
            CH_LC_T: esc_c = CH_TAB;
            CH_LC_R: esc_c = CH_CR;
            CH_LC_N: esc_c = CH_LF;
            default: esc_c = i_byte_value;
        endcase
    end

    always_comb begin
        case (r_mode)
            M_QUOTE, M_ESC: mode_tok = TK_QUOTED;
            M_BARE:         mode_tok = TK_BARE;
            M_CODE:         mode_tok = TK_CODE;
            M_COMMENT:      mode_tok = TK_COMMENT;
            default:        mode_tok = TK_LITERAL;
        endcase
    end

    always_comb begin
        n_line  = r_line;
        n_col   = r_col;
        if (r_mode != M_FAILED && r_mode != M_ENDED && !i_end_of_input) begin
            if (i_byte_value == CH_LF) begin
                if (!(&r_line)) n_line = r_line + LINE_BITS'(1);
                n_col = '0;
            end else if (!(&r_col)) begin
                n_col = r_col + COL_BITS'(1);
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        num     = 2'd0;
        ev[0]   = '0;
        ev[1]   = '0;
        ev[2]   = '0;
        case (r_mode)
            M_FAILED: begin
            end
            M_ENDED: begin
                num    = 2'd1;
                ev[0]  = mk_event(EV_ERROR, TK_LITERAL, 8'd0, line16, col16, ERR_AFTER_END);
                n_mode = M_FAILED;
            end
            default: begin
                if (i_end_of_input) begin
                    if (r_mode == M_QUOTE || r_mode == M_ESC) begin
                        num    = 2'd1;
                        ev[0]  = mk_event(EV_ERROR, TK_LITERAL, 8'd0, tline16, tcol16,
                                          ERR_UNEXP_END);
                        n_mode = M_FAILED;
                    end else begin
                        n_tline = n_line;
                        n_tcol  = n_col;
                        n_mode  = M_ENDED;
                        if (r_mode != M_INIT) begin
                            num   = 2'd2;
                            ev[0] = mk_event(EV_END, mode_tok, 8'd0, tline16, tcol16,
                                             ERR_NONE);
                            ev[1] = mk_event(EV_END, TK_EOI, 8'd0, line16, col16, ERR_NONE);
                        end else begin
                            num   = 2'd1;
                            ev[0] = mk_event(EV_END, TK_EOI, 8'd0, line16, col16, ERR_NONE);
                        end
                    end
                end else begin
                    case (r_mode)
                        M_INIT: begin
                            num    = sc.num;
                            ev[0]  = sc.e0;
                            ev[1]  = sc.e1;
                            n_mode = sc.mode;
                            if (sc.mark) begin
                                n_tline = n_line;
                                n_tcol  = n_col;
                            end
                        end
                        M_QUOTE: begin
                            if (i_byte_value == CH_BSLASH) begin
                                n_mode = M_ESC;
                            end else if (i_byte_value == CH_LF || i_byte_value == CH_CR) begin
                                num    = 2'd1;
                                ev[0]  = mk_event(EV_ERROR, TK_LITERAL, 8'd0, tline16, tcol16,
                                                  ERR_NO_QUOTE);
                                n_mode = M_FAILED;
                            end else if (i_byte_value == CH_DQUOTE) begin
                                num    = 2'd1;
                                ev[0]  = mk_event(EV_END, TK_QUOTED, 8'd0, tline16, tcol16,
                                                  ERR_NONE);
                                n_mode = M_INIT;
                            end else begin
                                num   = 2'd1;
                                ev[0] = mk_event(EV_CHAR, TK_QUOTED, i_byte_value, 16'd0,
                                                 16'd0, ERR_NONE);
                            end
                        end
                        M_ESC: begin
                            num    = 2'd1;
                            ev[0]  = mk_event(EV_CHAR, TK_QUOTED, esc_c, 16'd0, 16'd0,
                                              ERR_NONE);
                            n_mode = M_QUOTE;
                        end
                        M_BARE: begin
                            if (is_word(i_byte_value)) begin
                                num   = 2'd1;
                                ev[0] = mk_event(EV_CHAR, TK_BARE, i_byte_value, 16'd0,
                                                 16'd0, ERR_NONE);
                            end else begin
                                num    = sc.num + 2'd1;
                                ev[0]  = mk_event(EV_END, TK_BARE, 8'd0, tline16, tcol16,
                                                  ERR_NONE);
                                ev[1]  = sc.e0;
                                ev[2]  = sc.e1;
                                n_mode = sc.mode;
                                if (sc.mark) begin
                                    n_tline = n_line;
                                    n_tcol  = n_col;
                                end
                            end
                        end
                        default: begin
                            if (i_byte_value == CH_CR || i_byte_value == CH_LF) begin
                                num    = 2'd1;
                                ev[0]  = mk_event(EV_END, mode_tok, 8'd0, tline16, tcol16,
                                                  ERR_NONE);
                                n_mode = M_INIT;
                            end else begin
                                num   = 2'd1;
                                ev[0] = mk_event(EV_CHAR, mode_tok, i_byte_value, 16'd0,
                                                 16'd0, ERR_NONE);
                            end
                        end
                    endcase
                end
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            ev[k].last = (num == 2'(k + 1));
        end
    end

    always_comb begin
        n_cnt = r_cnt + (accept ? CW'(num) : CW'(0)) - (pop ? CW'(1) : CW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_INIT;
            r_line  <= LINE_BITS'(1);
            r_col   <= '0;
            r_tline <= '0;
            r_tcol  <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_cnt   <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (pop) r_rd <= r_rd + Q_AW'(1);
            if (accept) begin
                r_mode  <= n_mode;
                r_line  <= n_line;
                r_col   <= n_col;
                r_tline <= n_tline;
                r_tcol  <= n_tcol;
                r_wr    <= r_wr + Q_AW'(num);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (accept && (2'(k) < num)) r_q[r_wr + Q_AW'(k)] <= ev[k];
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(Q_DEPTH))
        else $error("result queue overfilled");

    a_failed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_FAILED) |-> (num == 2'd0))
        else $error("events produced after failure");

    a_events_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && num != 2'd0) |=> o_valid)
        else $error("accepted events not presented");

    a_line_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_line >= $past(r_line)))
        else $error("line counter went backwards");

endmodule

`default_nettype wire
